FILE: sv/nmea_gga_rmc_position_parser_macros.svh
// ---------------------------------------------------------------------------
// assertion macros for the position parser
// expects clk_i and rst_ni in the scope of use
// ---------------------------------------------------------------------------
`ifndef NMEA_GGA_RMC_POSITION_PARSER_MACROS_SVH
`define NMEA_GGA_RMC_POSITION_PARSER_MACROS_SVH

// plain property, checked outside reset
`define NGP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// overlapping implication, checked outside reset
`define NGP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: sv/ngp_pkg.sv
// ---------------------------------------------------------------------------
// ngp_pkg
// shared types and constants of the position parser
// ---------------------------------------------------------------------------
`default_nettype none

package ngp_pkg;

  localparam int unsigned LINE_LIMIT      = 128;
  localparam int unsigned FIELD_LIMIT     = 19;
  localparam int unsigned FRACTION_DIGITS = 5;
  localparam int unsigned NSTG            = 5;

  // coordinate conversion constants (fraction scale 1e5)
  localparam logic [16:0] INT_CAP    = 17'd99999;
  localparam logic [30:0] MAG_CAP    = 31'd1800000000;
  localparam logic [17:0] RECIP_100  = 18'd167773;    // ceil(2^24/100)
  localparam logic [25:0] RECIP_3    = 26'd44739243;  // (2^27+1)/3

  typedef enum logic [1:0] {
    KIND_GGA      = 2'd0,
    KIND_RMC_OK   = 2'd1,
    KIND_RMC_VOID = 2'd2
  } kind_e;

  // raw coordinate as read from the sentence
  typedef struct packed {
    logic [16:0] ipart;
    logic [16:0] frac;
    logic [2:0]  digits;
  } coord_raw_t;

  // non-coordinate part of one emitted record
  typedef struct packed {
    kind_e       kind;
    logic        neg_lat;
    logic        neg_lon;
    logic [3:0]  fix;
    logic [6:0]  sats;
    logic [16:0] alt;
    logic [16:0] speed;
  } side_t;

  function automatic logic [16:0] pow10(input logic [2:0] n);
    logic [16:0] r;
    case (n)
      3'd0:    r = 17'd1;
      3'd1:    r = 17'd10;
      3'd2:    r = 17'd100;
      3'd3:    r = 17'd1000;
      3'd4:    r = 17'd10000;
      3'd5:    r = 17'd100000;
      default: r = 17'd1;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: sv/ngp_if.sv
// ---------------------------------------------------------------------------
// ngp channels
// byte input channel and position record output channel
// ---------------------------------------------------------------------------
`default_nettype none

interface ngp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ngp_fix_if;
  logic               valid;
  logic               ready;
  logic [1:0]         sentence_kind;
  logic signed [31:0] latitude_e7;
  logic signed [31:0] longitude_e7;
  logic [16:0]        altitude_m;
  logic [3:0]         fix_quality;
  logic [6:0]         satellites;
  logic [16:0]        speed_knots;
  modport source (output valid, output sentence_kind, output latitude_e7,
                  output longitude_e7, output altitude_m, output fix_quality,
                  output satellites, output speed_knots, input ready);
  modport sink   (input valid, input sentence_kind, input latitude_e7,
                  input longitude_e7, input altitude_m, input fix_quality,
                  input satellites, input speed_knots, output ready);
endinterface

`default_nettype wire

FILE: sv/nmea_gga_rmc_position_parser.sv
// ---------------------------------------------------------------------------
// nmea_gga_rmc_position_parser
// parses gga and rmc sentences byte by byte and emits the position record
// ---------------------------------------------------------------------------
// One byte beat is taken every cycle that ready is high. Header matching
// and field accumulation happen in the cycle the byte arrives; a newline
// that ends a matched sentence pushes a record into a five stage elastic
// conversion pipeline (divide by 100, fraction scaling, minute to degree
// scaling through a split reciprocal multiply), whose last stage feeds the
// output register that presents the record. The pipeline stages and
// the output register each hold one record, so bytes keep flowing while a
// result waits on the output side; only a full pipeline with a stalled
// output lowers ready. The checksum is not checked. The output record
// fields are the held values: a void rmc only clears the fix and repeats
// the last position.
// ---------------------------------------------------------------------------
`default_nettype none

`include "nmea_gga_rmc_position_parser_macros.svh"

module nmea_gga_rmc_position_parser import ngp_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  ngp_byte_if.sink    byte_i,
  ngp_fix_if.source   fix_o
);

  typedef enum logic [3:0] {
    R_NONE, R_LAT, R_LATDIR, R_LON, R_LONDIR, R_FIX, R_SATS, R_ALT, R_STATUS, R_SPEED
  } role_e;

  typedef enum logic [1:0] {
    ST_NONE = 2'd0,
    ST_GGA  = 2'd1,
    ST_RMC  = 2'd2
  } stype_e;

  localparam logic [6:0] LINE_MAX = 7'(LINE_LIMIT - 1);
  localparam logic [7:0] HDR [4][6] = '{
    '{8'h24, "G", "N", "G", "G", "A"},
    '{8'h24, "G", "P", "G", "G", "A"},
    '{8'h24, "G", "N", "R", "M", "C"},
    '{8'h24, "G", "P", "R", "M", "C"}
  };

  // parser state
  logic [6:0]  lp_q, lp_d;
  logic [4:0]  fn_q, fn_d;
  logic [4:0]  fcc_q, fcc_d;
  logic [3:0]  hm_q, hm_d;
  stype_e      st_q, st_d;
  logic [16:0] ia_q, ia_d;
  logic [16:0] fa_q, fa_d;
  logic [2:0]  fd_q, fd_d;
  logic [1:0]  np_q, np_d;          // 0 integer, 1 fraction, 2 done
  logic        fs_q, fs_d;          // field stopped
  coord_raw_t  plat_q, plat_d, plon_q, plon_d;
  logic [1:0]  pdir_q, pdir_d;
  logic [3:0]  pfix_q, pfix_d;
  logic [6:0]  psats_q, psats_d;
  logic [16:0] palt_q, palt_d, pspd_q, pspd_d;
  logic        sv_q, sv_d;

  // emit snapshot
  logic        emit;
  side_t       snap_side;
  coord_raw_t  snap_lat, snap_lon;

  // pipeline control
  logic [NSTG-1:0] v_q;
  logic [NSTG:0]   rdy;
  side_t           side_q [NSTG];
  logic            accept;
  logic [30:0]     lat_mag, lon_mag;

  // output register doubles as the held record
  logic               out_valid_q;
  kind_e              kind_q;
  logic signed [31:0] lat_q, lon_q;
  logic [16:0]        alt_q, spd_q;
  logic [3:0]         fix_q;
  logic [6:0]         sats_q;

  function automatic role_e field_role(input stype_e st, input logic [4:0] fn);
    role_e r;
    r = R_NONE;
    case (st)
      ST_GGA: begin
        case (fn)
          5'd2:    r = R_LAT;
          5'd3:    r = R_LATDIR;
          5'd4:    r = R_LON;
          5'd5:    r = R_LONDIR;
          5'd6:    r = R_FIX;
          5'd7:    r = R_SATS;
          5'd9:    r = R_ALT;
          default: r = R_NONE;
        endcase
      end
      ST_RMC: begin
        case (fn)
          5'd2:    r = R_STATUS;
          5'd3:    r = R_LAT;
          5'd4:    r = R_LATDIR;
          5'd5:    r = R_LON;
          5'd6:    r = R_LONDIR;
          5'd7:    r = R_SPEED;
          default: r = R_NONE;
        endcase
      end
      default: r = R_NONE;
    endcase
    return r;
  endfunction

  function automatic logic [16:0] add_digit(input logic [16:0] acc, input logic [3:0] d);
    logic [20:0] v;
    v = 21'(acc) * 21'd10 + 21'(d);
    return (v > 21'(INT_CAP)) ? INT_CAP : v[16:0];
  endfunction

  assign accept = byte_i.valid && byte_i.ready;

  // per-byte parse
  always_comb begin
    logic [7:0]  c;
    logic        dig;
    logic [3:0]  d;
    logic [6:0]  pos;
    logic [4:0]  idx;
    role_e       r;
    c   = byte_i.rx_byte;
    dig = (c >= "0") && (c <= "9");
    d   = 4'(c - "0");
    pos = lp_q;
    idx = fcc_q;
    r   = R_NONE;

    lp_d = lp_q;  fn_d = fn_q;  fcc_d = fcc_q; hm_d = hm_q;  st_d = st_q;
    ia_d = ia_q;  fa_d = fa_q;  fd_d = fd_q;   np_d = np_q;  fs_d = fs_q;
    plat_d = plat_q; plon_d = plon_q; pdir_d = pdir_q; pfix_d = pfix_q;
    psats_d = psats_q; palt_d = palt_q; pspd_d = pspd_q; sv_d = sv_q;
    emit = 1'b0;

    // start of sentence
    if (c == "$") begin
      lp_d = '0; fn_d = '0; hm_d = 4'hF; st_d = ST_NONE;
      fcc_d = '0; ia_d = '0; fa_d = '0; fd_d = '0; np_d = '0; fs_d = 1'b0;
      plat_d = '0; plon_d = '0; pdir_d = '0; pfix_d = '0;
      psats_d = '0; palt_d = '0; pspd_d = '0; sv_d = 1'b0;
    end

    if (lp_d < LINE_MAX) begin
      if (c == 8'd0) begin
        lp_d = LINE_MAX;
      end else begin
        pos  = lp_d;
        lp_d = lp_d + 7'd1;
        if (pos < 7'd6) begin
          for (int k = 0; k < 4; k++) begin
            if (HDR[k][pos[2:0]] != c) hm_d[k] = 1'b0;
          end
          if (pos == 7'd5) begin
            st_d = (hm_d[1:0] != 2'b00) ? ST_GGA :
                   ((hm_d[3:2] != 2'b00) ? ST_RMC : ST_NONE);
          end
        end
        r = field_role(st_d, fn_d);
        if (c == ",") begin
          case (r)
            R_LAT:   plat_d = '{ipart: ia_d, frac: fa_d, digits: fd_d};
            R_LON:   plon_d = '{ipart: ia_d, frac: fa_d, digits: fd_d};
            R_SATS:  psats_d = ia_d[6:0];
            R_ALT:   palt_d = ia_d;
            R_SPEED: pspd_d = ia_d;
            default: ;
          endcase
          if (fn_d < 5'd31) fn_d = fn_d + 5'd1;
          fcc_d = '0; ia_d = '0; fa_d = '0; fd_d = '0; np_d = '0; fs_d = 1'b0;
        end else if (!fs_d) begin
          if (c == "*") begin
            fs_d = 1'b1;
          end else begin
            idx   = fcc_d;
            fcc_d = fcc_d + 5'd1;
            if (fcc_d >= 5'(FIELD_LIMIT)) fs_d = 1'b1;
            case (r)
              R_LATDIR: if (idx == '0 && (c == "S" || c == "W")) pdir_d[0] = 1'b1;
              R_LONDIR: if (idx == '0 && (c == "S" || c == "W")) pdir_d[1] = 1'b1;
              R_STATUS: if (idx == '0) sv_d = (c == "A");
              R_FIX:    if (idx == '0) pfix_d = dig ? d : 4'd0;
              R_LAT, R_LON: begin
                if (np_d == 2'd0) begin
                  if (c == ".") np_d = 2'd1;
                  else if (dig) ia_d = add_digit(ia_d, d);
                end else if (np_d == 2'd1) begin
                  if (!dig) np_d = 2'd2;
                  else if (fd_d < 3'(FRACTION_DIGITS)) begin
                    fa_d = 17'(fa_d * 4'd10) + 17'(d);
                    fd_d = fd_d + 3'd1;
                  end
                end
              end
              R_SATS: begin
                if (idx < 5'd2) begin
                  if (np_d == 2'd0 && dig) ia_d = add_digit(ia_d, d);
                  else np_d = 2'd2;
                end
              end
              R_ALT, R_SPEED: begin
                if (np_d == 2'd0 && dig) ia_d = add_digit(ia_d, d);
                else np_d = 2'd2;
              end
              default: ;
            endcase
          end
        end
      end
    end

    // newline closes the last field and ends the line
    snap_lat  = plat_d;
    snap_lon  = plon_d;
    snap_side = '{kind: KIND_GGA, neg_lat: pdir_d[0], neg_lon: pdir_d[1],
                  fix: pfix_d, sats: psats_d, alt: palt_d, speed: pspd_d};
    if (c == 8'h0A) begin
      r = field_role(st_d, fn_d);
      case (r)
        R_LAT:   snap_lat = '{ipart: ia_d, frac: fa_d, digits: fd_d};
        R_LON:   snap_lon = '{ipart: ia_d, frac: fa_d, digits: fd_d};
        R_SATS:  snap_side.sats = ia_d[6:0];
        R_ALT:   snap_side.alt = ia_d;
        R_SPEED: snap_side.speed = ia_d;
        default: ;
      endcase
      snap_side.kind = (st_d == ST_GGA) ? KIND_GGA :
                       (sv_d ? KIND_RMC_OK : KIND_RMC_VOID);
      emit = (st_d != ST_NONE);
      lp_d = '0; fn_d = '0; hm_d = 4'hF; st_d = ST_NONE;
      fcc_d = '0; ia_d = '0; fa_d = '0; fd_d = '0; np_d = '0; fs_d = 1'b0;
      plat_d = '0; plon_d = '0; pdir_d = '0; pfix_d = '0;
      psats_d = '0; palt_d = '0; pspd_d = '0; sv_d = 1'b0;
    end
  end

  // elastic ready chain, output end first
  always_comb begin
    rdy[NSTG] = !out_valid_q || fix_o.ready;
    for (int i = NSTG - 1; i >= 0; i--) begin
      rdy[i] = !v_q[i] || rdy[i+1];
    end
  end

  assign byte_i.ready = rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lp_q <= '0; fn_q <= '0; fcc_q <= '0; hm_q <= '0; st_q <= ST_NONE;
      ia_q <= '0; fa_q <= '0; fd_q <= '0; np_q <= '0; fs_q <= 1'b0;
      plat_q <= '0; plon_q <= '0; pdir_q <= '0; pfix_q <= '0;
      psats_q <= '0; palt_q <= '0; pspd_q <= '0; sv_q <= 1'b0;
    end else if (accept) begin
      lp_q <= lp_d; fn_q <= fn_d; fcc_q <= fcc_d; hm_q <= hm_d; st_q <= st_d;
      ia_q <= ia_d; fa_q <= fa_d; fd_q <= fd_d; np_q <= np_d; fs_q <= fs_d;
      plat_q <= plat_d; plon_q <= plon_d; pdir_q <= pdir_d; pfix_q <= pfix_d;
      psats_q <= psats_d; palt_q <= palt_d; pspd_q <= pspd_d; sv_q <= sv_d;
    end
  end

  // record pipeline valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= accept && emit;
      for (int i = 1; i < NSTG; i++) begin
        if (rdy[i]) v_q[i] <= v_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) side_q[0] <= snap_side;
    for (int i = 1; i < NSTG; i++) begin
      if (rdy[i]) side_q[i] <= side_q[i-1];
    end
  end

  ngp_coord_conv u_lat (
    .clk_i (clk_i),
    .ld_i  (rdy[NSTG-1:0]),
    .raw_i (snap_lat),
    .mag_o (lat_mag)
  );

  ngp_coord_conv u_lon (
    .clk_i (clk_i),
    .ld_i  (rdy[NSTG-1:0]),
    .raw_i (snap_lon),
    .mag_o (lon_mag)
  );

  // output register, updated per sentence kind
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      kind_q <= KIND_GGA;
      lat_q <= '0; lon_q <= '0; alt_q <= '0; spd_q <= '0; fix_q <= '0; sats_q <= '0;
    end else if (rdy[NSTG]) begin
      out_valid_q <= v_q[NSTG-1];
      if (v_q[NSTG-1]) begin
        kind_q <= side_q[NSTG-1].kind;
        case (side_q[NSTG-1].kind)
          KIND_GGA: begin
            lat_q  <= side_q[NSTG-1].neg_lat ? -$signed({1'b0, lat_mag})
                                              : $signed({1'b0, lat_mag});
            lon_q  <= side_q[NSTG-1].neg_lon ? -$signed({1'b0, lon_mag})
                                              : $signed({1'b0, lon_mag});
            fix_q  <= side_q[NSTG-1].fix;
            sats_q <= side_q[NSTG-1].sats;
            alt_q  <= side_q[NSTG-1].alt;
          end
          KIND_RMC_OK: begin
            lat_q  <= side_q[NSTG-1].neg_lat ? -$signed({1'b0, lat_mag})
                                              : $signed({1'b0, lat_mag});
            lon_q  <= side_q[NSTG-1].neg_lon ? -$signed({1'b0, lon_mag})
                                              : $signed({1'b0, lon_mag});
            fix_q  <= 4'd1;
            spd_q  <= side_q[NSTG-1].speed;
          end
          default: begin
            fix_q  <= 4'd0;
          end
        endcase
      end
    end
  end

  assign fix_o.valid         = out_valid_q;
  assign fix_o.sentence_kind = kind_q;
  assign fix_o.latitude_e7   = lat_q;
  assign fix_o.longitude_e7  = lon_q;
  assign fix_o.altitude_m    = alt_q;
  assign fix_o.fix_quality   = fix_q;
  assign fix_o.satellites    = sats_q;
  assign fix_o.speed_knots   = spd_q;

  // checks
  `NGP_ASSERT(a_fcc_bound, fcc_q <= 5'(FIELD_LIMIT), "field char count past limit")
  `NGP_ASSERT_IMP(a_void_fix, out_valid_q && kind_q == KIND_RMC_VOID, fix_q == 4'd0, "void fix set")
  `NGP_ASSERT_IMP(a_ok_fix, out_valid_q && kind_q == KIND_RMC_OK, fix_q == 4'd1, "rmc fix not one")
  `NGP_ASSERT(a_lat_cap, lat_q <= 32'sd1800000000 && lat_q >= -32'sd1800000000, "latitude out of range")

endmodule

`default_nettype wire

FILE: sv/ngp_coord_conv.sv
// ---------------------------------------------------------------------------
// ngp_coord_conv
// ddmm.mmmmm to 1e-7 degree magnitude, five register stages
// ---------------------------------------------------------------------------
`default_nettype none

module ngp_coord_conv import ngp_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic [NSTG-1:0] ld_i,
  input  wire coord_raw_t      raw_i,
  output logic [30:0]          mag_o
);

  coord_raw_t  s1_q;
  logic [9:0]  s2_deg_q;
  logic [16:0] s2_ip_q, s2_fn_q;
  logic [6:0]  s3_min_q;
  logic [9:0]  s3_deg_q;
  logic [16:0] s3_fn_q;
  logic [25:0] s4_p_q;
  logic [33:0] s4_degp_q;
  logic [38:0] s5_ph_q, s5_pl_q;
  logic [33:0] s5_degp_q;

  logic [34:0] div_prod;
  logic [33:0] fn_prod;
  logic [16:0] min_full;
  logic [52:0] sum;
  logic [34:0] mag;

  always_comb begin
    div_prod = s1_q.ipart * RECIP_100;
    fn_prod  = s1_q.frac * pow10(3'(FRACTION_DIGITS) - s1_q.digits);
    min_full = s2_ip_q - 17'(s2_deg_q) * 17'd100;
    sum      = 53'({s5_ph_q, 13'd0}) + 53'(s5_pl_q);
    mag      = 35'(s5_degp_q) + 35'(sum[52:27]);
    mag_o    = (mag > 35'(MAG_CAP)) ? MAG_CAP : mag[30:0];
  end

  always_ff @(posedge clk_i) begin
    if (ld_i[0]) begin
      s1_q <= raw_i;
    end
    if (ld_i[1]) begin
      s2_deg_q <= div_prod[33:24];
      s2_ip_q  <= s1_q.ipart;
      s2_fn_q  <= fn_prod[16:0];
    end
    if (ld_i[2]) begin
      s3_min_q <= min_full[6:0];
      s3_deg_q <= s2_deg_q;
      s3_fn_q  <= s2_fn_q;
    end
    if (ld_i[3]) begin
      s4_p_q    <= 26'(s3_min_q) * 26'd500000 + 26'(s3_fn_q) * 26'd5;
      s4_degp_q <= 34'(s3_deg_q) * 34'd10000000;
    end
    if (ld_i[4]) begin
      s5_ph_q   <= s4_p_q[25:13] * RECIP_3;
      s5_pl_q   <= s4_p_q[12:0] * RECIP_3;
      s5_degp_q <= s4_degp_q;
    end
  end

endmodule

`default_nettype wire

FILE: bench/tb_ngp_channels.sv
// ---------------------------------------------------------------------------
// bench channels
// byte and position record channels seen by the testbench
// ---------------------------------------------------------------------------
// the channel interfaces of the RTL are used as they are; this file holds
// the record type the checker keeps per expected beat
package tb_ngp_types_pkg;
  import ngp_pkg::*;

  typedef struct {
    logic [1:0]         kind;
    logic signed [31:0] lat;
    logic signed [31:0] lon;
    logic [16:0]        alt;
    logic [3:0]         fix;
    logic [6:0]         sats;
    logic [16:0]        speed;
  } pos_rec_t;
endpackage

FILE: bench/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// regression bench of the nmea gga / rmc position parser
// ---------------------------------------------------------------------------
// Bytes are sent through the byte channel with random gaps. A behavioral
// parser inside the bench follows every accepted byte and queues the record
// each matched newline produces; the checker compares each output beat with
// the oldest queued record, field by field.
// ---------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ngp_pkg::*;
  import tb_ngp_types_pkg::*;

  localparam int STALL_LIMIT = 4000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  ngp_byte_if byte_ch ();
  ngp_fix_if  fix_ch ();

  nmea_gga_rmc_position_parser dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .byte_i (byte_ch.sink),
    .fix_o  (fix_ch.source)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------
  // behavioral parser state
  // ---------------------------------------------------------------------
  typedef enum int {F_NONE, F_LAT, F_LATDIR, F_LON, F_LONDIR, F_FIX, F_SATS,
                    F_ALT, F_STATUS, F_SPEED} field_use_e;

  int unsigned p_pos, p_field, p_chars, p_match, p_type;
  int unsigned p_int, p_frac, p_fdig, p_phase;
  bit          p_stop;
  longint unsigned p_lat_mag, p_lon_mag;
  int unsigned p_dirs, p_fix, p_sats, p_alt, p_speed, p_status;
  logic [31:0] h_lat, h_lon;
  int unsigned h_alt, h_fix, h_sats, h_speed;

  pos_rec_t expected_recs[$];
  int       fail_cnt = 0;
  int       idle_cycles = 0;

  function automatic void clear_field();
    p_chars = 0; p_int = 0; p_frac = 0; p_fdig = 0; p_phase = 0; p_stop = 0;
  endfunction

  function automatic void new_line();
    p_pos = 0; p_field = 0; p_match = 4'hF; p_type = 0;
    clear_field();
    p_lat_mag = 0; p_lon_mag = 0; p_dirs = 0;
    p_fix = 0; p_sats = 0; p_alt = 0; p_speed = 0; p_status = 0;
  endfunction

  function automatic field_use_e field_use();
    if (p_type == 1) begin
      case (p_field)
        2: return F_LAT;
        3: return F_LATDIR;
        4: return F_LON;
        5: return F_LONDIR;
        6: return F_FIX;
        7: return F_SATS;
        9: return F_ALT;
        default: return F_NONE;
      endcase
    end
    if (p_type == 2) begin
      case (p_field)
        2: return F_STATUS;
        3: return F_LAT;
        4: return F_LATDIR;
        5: return F_LON;
        6: return F_LONDIR;
        7: return F_SPEED;
        default: return F_NONE;
      endcase
    end
    return F_NONE;
  endfunction

  function automatic int unsigned push_digit(int unsigned acc, int unsigned d);
    int unsigned v;
    v = acc * 10 + d;
    return (v > 99999) ? 99999 : v;
  endfunction

  // ddmm.mmmmm to 1e-7 degrees, truncated and saturated
  function automatic longint unsigned coord_mag();
    longint unsigned scale, frac, deg, mins, mag;
    scale = 100000;
    frac = p_frac;
    for (int i = p_fdig; i < FRACTION_DIGITS; i++) frac *= 10;
    deg = p_int / 100;
    mins = p_int % 100;
    mag = deg * 64'd10000000 + ((mins * scale + frac) * 64'd10000000) / (60 * scale);
    return (mag > 64'd1800000000) ? 64'd1800000000 : mag;
  endfunction

  function automatic void end_field();
    case (field_use())
      F_LAT:   p_lat_mag = coord_mag();
      F_LON:   p_lon_mag = coord_mag();
      F_SATS:  p_sats = p_int;
      F_ALT:   p_alt = p_int;
      F_SPEED: p_speed = p_int;
      default: ;
    endcase
  endfunction

  function automatic void digit_lead(int unsigned c);
    if (p_phase == 0 && c >= "0" && c <= "9") p_int = push_digit(p_int, c - "0");
    else p_phase = 2;
  endfunction

  function automatic void coord_char(int unsigned c);
    bit dig;
    dig = c >= "0" && c <= "9";
    if (p_phase == 0) begin
      if (c == ".") p_phase = 1;
      else if (dig) p_int = push_digit(p_int, c - "0");
    end else if (p_phase == 1) begin
      if (!dig) p_phase = 2;
      else if (p_fdig < FRACTION_DIGITS) begin
        p_frac = p_frac * 10 + (c - "0");
        p_fdig++;
      end
    end
  endfunction

  function automatic void take_char(int unsigned c);
    string hdr[4];
    int unsigned pos, idx;
    hdr[0] = "$GNGGA"; hdr[1] = "$GPGGA"; hdr[2] = "$GNRMC"; hdr[3] = "$GPRMC";
    pos = p_pos;
    p_pos++;
    if (pos < 6) begin
      for (int k = 0; k < 4; k++)
        if (hdr[k][pos] != c[7:0]) p_match &= ~(1 << k);
      if (pos == 5)
        p_type = (p_match & 3) ? 1 : ((p_match & 12) ? 2 : 0);
    end
    if (c == ",") begin
      end_field();
      if (p_field < 31) p_field++;
      clear_field();
      return;
    end
    if (p_stop) return;
    if (c == "*") begin
      p_stop = 1;
      return;
    end
    idx = p_chars;
    p_chars++;
    if (p_chars >= FIELD_LIMIT) p_stop = 1;
    case (field_use())
      F_LATDIR: if (idx == 0 && (c == "S" || c == "W")) p_dirs |= 1;
      F_LONDIR: if (idx == 0 && (c == "S" || c == "W")) p_dirs |= 2;
      F_STATUS: if (idx == 0) p_status = (c == "A");
      F_FIX:    if (idx == 0) p_fix = (c >= "0" && c <= "9") ? c - "0" : 0;
      F_LAT, F_LON: coord_char(c);
      F_SATS:   if (idx < 2) digit_lead(c);
      F_ALT, F_SPEED: digit_lead(c);
      default: ;
    endcase
  endfunction

  function automatic logic [31:0] apply_sign(longint unsigned mag, bit neg);
    return neg ? 32'(64'h1_0000_0000 - mag) : 32'(mag);
  endfunction

  function automatic void close_line();
    pos_rec_t r;
    end_field();
    if (p_type == 1) begin
      h_lat = apply_sign(p_lat_mag, p_dirs[0]);
      h_lon = apply_sign(p_lon_mag, p_dirs[1]);
      h_fix = p_fix; h_sats = p_sats; h_alt = p_alt;
      r.kind = KIND_GGA;
    end else if (p_type == 2) begin
      if (p_status) begin
        h_lat = apply_sign(p_lat_mag, p_dirs[0]);
        h_lon = apply_sign(p_lon_mag, p_dirs[1]);
        h_fix = 1; h_speed = p_speed;
        r.kind = KIND_RMC_OK;
      end else begin
        h_fix = 0;
        r.kind = KIND_RMC_VOID;
      end
    end else begin
      return;
    end
    r.lat = h_lat; r.lon = h_lon;
    r.alt = 17'(h_alt); r.fix = 4'(h_fix);
    r.sats = 7'(h_sats); r.speed = 17'(h_speed);
    expected_recs.push_back(r);
  endfunction

  // follows one accepted byte
  function automatic void parse_byte(logic [7:0] b);
    int unsigned c;
    c = b;
    if (c == "$") new_line();
    if (p_pos < LINE_LIMIT - 1) begin
      if (c == 0) p_pos = LINE_LIMIT - 1;
      else take_char(c);
    end
    if (c == 8'h0A) begin
      close_line();
      new_line();
    end
  endfunction

  // ---------------------------------------------------------------------
  // stimulus side
  // ---------------------------------------------------------------------
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  bit gaps_on = 1;

  // sends one byte beat, valid held until accepted and kept up for the next
  // beat unless a gap follows
  task automatic send_byte(input logic [7:0] b);
    int g;
    g = gaps_on ? gap_len() : 0;
    if (g > 0) begin
      byte_ch.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    byte_ch.valid   <= 1'b1;
    byte_ch.rx_byte <= b;
    do @(posedge clk_i); while (!byte_ch.ready);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // byte accept monitor feeds the behavioral parser
  always @(posedge clk_i) begin
    if (rst_ni && byte_ch.valid && byte_ch.ready) parse_byte(byte_ch.rx_byte);
  end

  // ---------------------------------------------------------------------
  // result side: random stalls and field checks
  // ---------------------------------------------------------------------
  bit stalls_on = 1;
  int stall_left = 0;

  always @(posedge clk_i) begin
    int r;
    r = $urandom_range(0, 99);
    if (!stalls_on) fix_ch.ready <= 1'b1;
    else if (stall_left > 0) begin
      stall_left--;
      fix_ch.ready <= 1'b0;
    end else if (r == 0) begin
      stall_left = $urandom_range(10, 60);
      fix_ch.ready <= 1'b0;
    end
    else if (r < 60) fix_ch.ready <= 1'b1;
    else if (r < 97) fix_ch.ready <= 1'b0;
    else fix_ch.ready <= ($urandom_range(0, 1) == 1);
  end

  always @(posedge clk_i) begin
    pos_rec_t e;
    if (rst_ni && fix_ch.valid && fix_ch.ready) begin
      if (expected_recs.size() == 0) begin
        $error("record beat with no record expected");
        fail_cnt++;
      end else begin
        e = expected_recs.pop_front();
        if (fix_ch.sentence_kind !== e.kind) begin
          $error("sentence_kind exp %0d got %0d", e.kind, fix_ch.sentence_kind);
          fail_cnt++;
        end
        if (fix_ch.latitude_e7 !== e.lat) begin
          $error("latitude_e7 exp %0d got %0d", e.lat, fix_ch.latitude_e7);
          fail_cnt++;
        end
        if (fix_ch.longitude_e7 !== e.lon) begin
          $error("longitude_e7 exp %0d got %0d", e.lon, fix_ch.longitude_e7);
          fail_cnt++;
        end
        if (fix_ch.altitude_m !== e.alt) begin
          $error("altitude_m exp %0d got %0d", e.alt, fix_ch.altitude_m);
          fail_cnt++;
        end
        if (fix_ch.fix_quality !== e.fix) begin
          $error("fix_quality exp %0d got %0d", e.fix, fix_ch.fix_quality);
          fail_cnt++;
        end
        if (fix_ch.satellites !== e.sats) begin
          $error("satellites exp %0d got %0d", e.sats, fix_ch.satellites);
          fail_cnt++;
        end
        if (fix_ch.speed_knots !== e.speed) begin
          $error("speed_knots exp %0d got %0d", e.speed, fix_ch.speed_knots);
          fail_cnt++;
        end
      end
    end
  end

  // watchdog: cycles with no beat on either side
  always @(posedge clk_i) begin
    if ((byte_ch.valid && byte_ch.ready) || (fix_ch.valid && fix_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // sentence builders
  // ---------------------------------------------------------------------
  function automatic string digits(int n);
    string s;
    s = "";
    for (int i = 0; i < n; i++) s = {s, $sformatf("%0d", $urandom_range(0, 9))};
    return s;
  endfunction

  function automatic string rand_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return "";
    if (r == 1) return {digits($urandom_range(1, 7)), ".", digits($urandom_range(0, 8))};
    if (r == 2) return {digits(2), "x", digits(2), ".", digits(2), "z"};
    return {digits($urandom_range(4, 5)), ".", digits($urandom_range(1, 6))};
  endfunction

  function automatic string rand_num();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return "";
    if (r == 1) return {"-", digits(2)};
    if (r == 2) return digits($urandom_range(5, 8));
    return {digits($urandom_range(1, 4)), ".", digits(1)};
  endfunction

  function automatic string rand_dir(input bit lat);
    int r;
    r = $urandom_range(0, 5);
    if (r == 0) return "";
    if (r == 1) return "S";
    if (r == 2) return "W";
    if (r == 3) return "X";
    return lat ? "N" : "E";
  endfunction

  function automatic string talker();
    return $urandom_range(0, 1) ? "GN" : "GP";
  endfunction

  function automatic string rand_gga();
    string fx;
    fx = $urandom_range(0, 5) == 0 ? "x" : digits(1);
    return {"$", talker(), "GGA,", digits(6), ".00,", rand_coord(), ",", rand_dir(1), ",",
            rand_coord(), ",", rand_dir(0), ",", fx, ",", rand_num(), ",0.9,",
            rand_num(), ",M,,M,,*", digits(2), "\r\n"};
  endfunction

  function automatic string rand_rmc();
    string st;
    int r;
    r = $urandom_range(0, 5);
    st = r < 4 ? "A" : (r == 4 ? "V" : "");
    return {"$", talker(), "RMC,", digits(6), ".00,", st, ",", rand_coord(), ",",
            rand_dir(1), ",", rand_coord(), ",", rand_dir(0), ",", rand_num(),
            ",,010124,,,A*", digits(2), "\r\n"};
  endfunction

  // ---------------------------------------------------------------------
  // test tasks
  // ---------------------------------------------------------------------
  task automatic wait_drained();
    byte_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_recs.size() != 0) @(posedge clk_i);
  endtask

  // short directed set: extremes, both kinds, signs
  task automatic test_directed();
    send_text("$GPGGA,1,9000.00000,S,18000.0,W,2,12,,99999999,M*\n");
    send_text("$GNRMC,1,A,0000.0,N,0.0,E,123456*\n");
  endtask

  task automatic test_edge_cases();
    send_text("$GNRMC,1,V,1,N*\n");          // void rmc clears fix only
    send_text("$GPRMC,1,,*\n");               // missing status counts as not A
    send_text("$GNGGA,,,,,,,\r\n");           // all fields empty
    send_text("$XXGGA,1,2\n");                // unknown header, no record
    send_text("junk\n");                      // no leading dollar
    send_byte(8'h00);                         // zero byte ends visible line
    send_byte(8'hFF);
    send_text("\n");
    send_text("$GPGGA,1,4530.1234567,S,12*3,W,x,7a,,-5\n");
    send_text("$GPGGA,1,1234567890123456789012345,N\n"); // field limit
  endtask

  task automatic test_long_line();
    string s;
    s = "$GNRMC,1,A,1111.1,S,2222.2,W,5";
    for (int i = 0; i < 120; i++) s = {s, ","};
    send_text({s, "\n"});
  endtask

  task automatic test_drain_pause();
    send_text(rand_gga());
    wait_drained();
    repeat ($urandom_range(1, 10)) @(posedge clk_i);
    send_text(rand_rmc());
  endtask

  // output held back while short sentences stream in, so byte ready drops
  task automatic test_backpressure();
    gaps_on = 0;
    stall_left = 70;
    for (int i = 0; i < 16; i++) send_text("$GPGGA,,,\n");
    gaps_on = 1;
  endtask

  task automatic test_random_bytes(input int count);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 9);
      if (r < 6) send_byte(8'($urandom_range(0, 255)));
      else if (r < 8) send_byte(8'h0A);
      else send_byte("$");
    end
  endtask

  task automatic test_random_sentences(input int target_bytes);
    int sent;
    int r;
    string s;
    sent = 0;
    while (sent < target_bytes) begin
      r = $urandom_range(0, 19);
      gaps_on = ($urandom_range(0, 7) != 0);
      stalls_on = ($urandom_range(0, 7) != 0);
      if (r < 9) s = rand_gga();
      else if (r < 17) s = rand_rmc();
      else if (r < 19) begin
        s = rand_gga();
        s = {s.substr(0, $urandom_range(5, 30)), "\n"};
      end
      else s = {"$", talker(), "GSV,3,1*", digits(2), "\n"};
      send_text(s);
      sent += s.len();
    end
    gaps_on = 1;
    stalls_on = 1;
  endtask

  // ---------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------
  initial begin
    byte_ch.valid   = 1'b0;
    byte_ch.rx_byte = 8'h00;
    fix_ch.ready    = 1'b0;
    h_lat = 0; h_lon = 0; h_alt = 0; h_fix = 0; h_sats = 0; h_speed = 0;
    new_line();
    p_match = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_edge_cases();
    test_long_line();
    test_drain_pause();
    test_random_bytes(150);
    send_text("\n");
    test_backpressure();
    test_random_sentences(400);

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (fail_cnt == 0 && expected_recs.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

FILE: filelist.f
+incdir+sv
sv/ngp_pkg.sv
sv/ngp_if.sv
sv/ngp_coord_conv.sv
sv/nmea_gga_rmc_position_parser.sv
bench/tb_ngp_channels.sv
bench/tb_top.sv
